// ----- rtl/core/lng_pkg.sv -----
// lng_pkg: widths, register indexes, reset values and the life rule for the
// life_next_generation_stream block. No dependencies.
`default_nettype none

package lng_pkg;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 9;
   localparam int ROWS_CFG_W  = 9;
   localparam int COLS_CFG_W  = 8;
   localparam int OUT_ROW_W   = 8;
   localparam int OUT_COL_W   = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'd1;

   // item kinds on the input channel
   localparam logic ITEM_CELL  = 1'b0;
   localparam logic ITEM_FLUSH = 1'b1;

   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 9'd45;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd78;

   localparam int MIN_DIM = 3;

   typedef logic [3:0] nb_count_type;

   // birth on three, survival on two or three
   function automatic logic life_rule(input logic alive, input logic [7:0] nb);
      nb_count_type n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + nb_count_type'(nb[i]);
      end
      return (n == 4'd3) || (alive && (n == 4'd2));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lng_req_if.sv -----
// lng_req_if: input channel carrying one grid cell or flush item per transfer
// depends on lng_pkg
`default_nettype none

interface lng_req_if;
   import lng_pkg::*;

   logic valid;
   logic ready;
   logic req_type;
   logic cell_alive;

   modport source (output valid, output req_type, output cell_alive, input ready);
   modport sink   (input valid, input req_type, input cell_alive, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lng_rsp_if.sv -----
// lng_rsp_if: result channel carrying the next state of one cell and its position
// depends on lng_pkg
`default_nettype none

interface lng_rsp_if;
   import lng_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 next_alive;
   logic [OUT_ROW_W-1:0] out_row;
   logic [OUT_COL_W-1:0] out_col;
   logic                 last_cell;

   modport source (output valid, output next_alive, output out_row, output out_col,
                   output last_cell, input ready);
   modport sink   (input valid, input next_alive, input out_row, input out_col,
                   input last_cell, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/life_next_generation_stream.sv -----
// life_next_generation_stream: streaming game of life next generation, raster cells in,
// next state of the cell one row up and one column left out
// depends on lng_pkg, lng_req_if, lng_rsp_if
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    req_type, cell_alive
//   rsp_chan  out  valid/ready    next_alive, out_row, out_col, last_cell
//   csr_*     in   csr_wr_en      csr_index, csr_wr_data
//
// one item per clock while the output is not stalled; an accepted item is registered
// in stage a (line store read), then in the output register (window update and rule)
// the line store is one two-bit-wide memory with one read and one write a cycle
// reset clears counters, window and valids at once; line stores need no clearing
// a stalled output holds the stage behind it, the intake keeps taking items while
// that stage is empty
`default_nettype none

module life_next_generation_stream #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [lng_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lng_pkg::CSR_DATA_W-1:0] csr_wr_data,
   lng_req_if.sink                             req_chan,
   lng_rsp_if.source                           rsp_chan
);
   import lng_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int COLW1  = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 3);

   // configuration
   logic [ROWS_CFG_W-1:0] rows_cfg_ff;
   logic [COLS_CFG_W-1:0] cols_cfg_ff;
   logic [ROW_W-1:0]      rows_eff;
   logic [ROW_W-1:0]      rows_p1;
   logic [COLW1-1:0]      cols_eff;

   // intake position
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] cur_row;
   logic [COL_W-1:0] cur_col;
   logic [COLW1-1:0] col_inc;
   logic             pos_ok;
   logic             col_wrap;
   logic             last_in;
   logic             bit_in;
   logic             accept;

   // stage a
   logic             a_valid_ff, a_valid_in;
   logic [ROW_W-1:0] a_row_ff;
   logic [COL_W-1:0] a_col_ff;
   logic             a_bit_ff;
   logic             a_adv;

   // line store, bit 0 upper line, bit 1 middle line
   logic [1:0]       line_mem [MAX_COLS];
   logic [1:0]       line_rd_ff;
   logic             fwd_ff;
   logic [1:0]       fwd_data_ff;
   logic [1:0]       line_q;

   // window and rule
   logic [8:0]       window_ff, window_in;
   logic [8:0]       nw;
   logic             emit0, emit1, emit;
   logic             top0, bot0, top1, bot1, left1, right1;
   logic [7:0]       nb0, nb1;
   logic             nxt;
   logic             last_out;
   logic [ROW_W-1:0] er;
   logic [COLW1-1:0] ec;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic                 out_next_ff;
   logic [OUT_ROW_W-1:0] out_row_ff;
   logic [OUT_COL_W-1:0] out_col_ff;
   logic                 out_last_ff;

   always_comb begin
      rows_eff = (rows_cfg_ff < ROWS_CFG_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) :
                 (32'(rows_cfg_ff) > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) :
                 ROW_W'(rows_cfg_ff);
      cols_eff = (cols_cfg_ff < COLS_CFG_W'(MIN_DIM)) ? COLW1'(MIN_DIM) :
                 (32'(cols_cfg_ff) > 32'(MAX_COLS)) ? COLW1'(MAX_COLS) :
                 COLW1'(cols_cfg_ff);
      rows_p1  = rows_eff + ROW_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= ROWS_RESET;
         cols_cfg_ff <= COLS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_cfg_ff <= csr_wr_data[ROWS_CFG_W-1:0];
            CSR_COLS_IN_USE: cols_cfg_ff <= csr_wr_data[COLS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // intake
   assign a_adv          = a_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !a_valid_ff || a_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      pos_ok   = (in_row_ff <= rows_p1) && (COLW1'(in_col_ff) < cols_eff);
      cur_row  = pos_ok ? in_row_ff : '0;
      cur_col  = pos_ok ? in_col_ff : '0;
      bit_in   = (req_chan.req_type == ITEM_CELL) && req_chan.cell_alive &&
                 (cur_row < rows_eff);
      last_in  = (cur_col == '0) && (cur_row == rows_p1);
      col_inc  = COLW1'(cur_col) + COLW1'(1);
      col_wrap = col_inc >= cols_eff;
      if (last_in) begin
         in_row_in = '0;
         in_col_in = '0;
      end else if (col_wrap) begin
         in_row_in = cur_row + ROW_W'(1);
         in_col_in = '0;
      end else begin
         in_row_in = cur_row;
         in_col_in = col_inc[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (accept) begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
      end
   end

   // stage a
   assign a_valid_in = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_row_ff    <= cur_row;
         a_col_ff    <= cur_col;
         a_bit_ff    <= bit_in;
         fwd_ff      <= a_adv && (a_col_ff == cur_col);
         fwd_data_ff <= {a_bit_ff, line_q[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         line_mem[a_col_ff] <= {a_bit_ff, line_q[1]};
      end
      if (accept) begin
         line_rd_ff <= line_mem[cur_col];
      end
   end

   assign line_q = fwd_ff ? fwd_data_ff : line_rd_ff;

   // window update and rule
   always_comb begin
      nw     = {a_bit_ff, line_q[1], line_q[0], window_ff[8:3]};
      emit0  = (a_col_ff == '0) && (a_row_ff >= ROW_W'(2));
      emit1  = (a_col_ff != '0) && (a_row_ff != '0);
      emit   = emit0 || emit1;
      top0   = a_row_ff > ROW_W'(2);
      bot0   = a_row_ff <= rows_eff;
      top1   = a_row_ff > ROW_W'(1);
      bot1   = a_row_ff < rows_eff;
      left1  = a_col_ff > COL_W'(1);
      right1 = COLW1'(a_col_ff) < cols_eff;
      nb0    = {window_ff[3] & top0, window_ff[4], window_ff[5] & bot0,
                window_ff[6] & top0, window_ff[8] & bot0, 3'b000};
      nb1    = {nw[0] & top1 & left1, nw[1] & left1, nw[2] & bot1 & left1,
                nw[3] & top1, nw[5] & bot1,
                nw[6] & top1 & right1, nw[7] & right1, nw[8] & bot1 & right1};
      if (emit0) begin
         nxt      = life_rule(window_ff[7], nb0);
         er       = a_row_ff - ROW_W'(2);
         ec       = cols_eff - COLW1'(1);
         last_out = a_row_ff == rows_p1;
      end else begin
         nxt      = life_rule(nw[4], nb1);
         er       = a_row_ff - ROW_W'(1);
         ec       = COLW1'(a_col_ff) - COLW1'(1);
         last_out = 1'b0;
      end
   end

   assign window_in = a_adv ? nw : window_ff;

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // output register
   assign out_valid_in = a_adv ? emit : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && emit) begin
         out_next_ff <= nxt;
         out_row_ff  <= OUT_ROW_W'(er);
         out_col_ff  <= OUT_COL_W'(ec);
         out_last_ff <= last_out;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.next_alive = out_next_ff;
   assign rsp_chan.out_row    = out_row_ff;
   assign rsp_chan.out_col    = out_col_ff;
   assign rsp_chan.last_cell  = out_last_ff;

   // checks
   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> a_valid_ff && out_valid_ff)
      else $error("intake stalled with a free stage");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && last_in |=> in_row_ff == '0 && in_col_ff == '0)
      else $error("position not restarted after the final item");

   a_last_at_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_cell |->
         32'(rsp_chan.out_col) == 32'(OUT_COL_W'(cols_eff - COLW1'(1))))
      else $error("final cell not in the last column");

   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> 32'(rsp_chan.out_row) < 32'(rows_eff))
      else $error("result row outside the grid");

endmodule

`default_nettype wire

// ----- verif/life_generation_checker.sv -----
`timescale 1ns / 100ps
// life_generation_checker: watches the cell and result channels of life_next_generation_stream,
// predicts each next-generation cell and compares it field by field
// depends on lng_pkg, lng_req_if, lng_rsp_if

module life_generation_checker #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [lng_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lng_pkg::CSR_DATA_W-1:0] csr_wr_data,
   lng_req_if                             req_chan,
   lng_rsp_if                             rsp_chan,
   output int                             mismatch_count,
   output int                             pending_cells
);
   import lng_pkg::*;

   typedef struct packed {
      logic                 next_alive;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 last_cell;
   } gen_cell_type;

   gen_cell_type          next_gen_cells[$];
   logic [ROWS_CFG_W-1:0] rows_reg;
   logic [COLS_CFG_W-1:0] cols_reg;
   logic                  upper_store[MAX_COLS];
   logic                  middle_store[MAX_COLS];
   logic [8:0]            window;
   int unsigned           at_row;
   int unsigned           at_col;

   function automatic int unsigned clamp_dim(input int unsigned value, input int unsigned hi);
      if (value < MIN_DIM) return MIN_DIM;
      if (value > hi) return hi;
      return value;
   endfunction

   // window bit of column k, row r is k*3 + r, column 0 oldest, row 0 top
   function automatic logic next_state(input logic [8:0] win, input int unsigned kc,
                                       input bit top_ok, input bit bot_ok,
                                       input bit left_ok, input bit right_ok);
      int unsigned live;
      int unsigned dk;
      int unsigned r;
      live = 0;
      for (dk = 0; dk < 3; dk++) begin
         for (r = 0; r < 3; r++) begin
            if ((dk == 1 && r == 1) || (dk == 0 && !left_ok) ||
                (dk == 2 && (!right_ok || kc == 2)) ||
                (r == 0 && !top_ok) || (r == 2 && !bot_ok)) continue;
            live += win[(kc + dk - 1) * 3 + r];
         end
      end
      return (live == 3) || (win[kc * 3 + 1] && live == 2);
   endfunction

   task automatic evolve_cell(input logic kind, input logic alive);
      int unsigned  rows;
      int unsigned  cols;
      int unsigned  r;
      int unsigned  c;
      int unsigned  er;
      int unsigned  ec;
      logic         bit_in;
      logic [2:0]   column;
      gen_cell_type predicted;
      bit           emit;
      rows = clamp_dim(rows_reg, MAX_ROWS);
      cols = clamp_dim(cols_reg, MAX_COLS);
      r = at_row;
      c = at_col;
      emit = 0;
      predicted = '0;
      if (r > rows + 1 || c >= cols) begin
         r = 0;
         c = 0;
      end
      bit_in = (kind == ITEM_CELL) && alive && (r < rows);

      // last column of the row two above, from the window before the shift
      if (c == 0 && r >= 2) begin
         er = r - 2;
         ec = cols - 1;
         predicted.next_alive = next_state(window, 2, er > 0, er + 1 < rows, 1'b1, 1'b0);
         predicted.row = er[OUT_ROW_W-1:0];
         predicted.col = ec[OUT_COL_W-1:0];
         predicted.last_cell = (r == rows + 1);
         emit = 1;
      end

      column = {bit_in, middle_store[c], upper_store[c]};
      upper_store[c] = middle_store[c];
      middle_store[c] = bit_in;
      window = {column, window[8:3]};

      if (c >= 1 && r >= 1) begin
         er = r - 1;
         ec = c - 1;
         predicted.next_alive = next_state(window, 1, er > 0, er + 1 < rows,
                                           ec > 0, ec + 1 < cols);
         predicted.row = er[OUT_ROW_W-1:0];
         predicted.col = ec[OUT_COL_W-1:0];
         predicted.last_cell = 1'b0;
         emit = 1;
      end

      if (predicted.last_cell) begin
         at_row = 0;
         at_col = 0;
      end else begin
         c++;
         if (c >= cols) begin
            c = 0;
            r++;
         end
         at_row = r;
         at_col = c;
      end
      if (emit) next_gen_cells.push_back(predicted);
   endtask

   always @(posedge clock) begin
      gen_cell_type want;
      gen_cell_type got;
      int           idx;
      if (reset) begin
         rows_reg = ROWS_RESET;
         cols_reg = COLS_RESET;
         window = '0;
         at_row = 0;
         at_col = 0;
         for (idx = 0; idx < MAX_COLS; idx++) begin
            upper_store[idx] = 1'b0;
            middle_store[idx] = 1'b0;
         end
         next_gen_cells.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en && (csr_index == CSR_ROWS_IN_USE || csr_index == CSR_COLS_IN_USE)) begin
            if (csr_index == CSR_ROWS_IN_USE) rows_reg = csr_wr_data[ROWS_CFG_W-1:0];
            else cols_reg = csr_wr_data[COLS_CFG_W-1:0];
            // frame restarts, line stores keep their contents
            window = '0;
            at_row = 0;
            at_col = 0;
         end
         if (req_chan.valid && req_chan.ready) begin
            evolve_cell(req_chan.req_type, req_chan.cell_alive);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.next_alive, rsp_chan.out_row, rsp_chan.out_col, rsp_chan.last_cell};
            if (next_gen_cells.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected result alive=%0d row=%0d col=%0d last=%0d",
                           $realtime, got.next_alive, got.row, got.col, got.last_cell);
               end
            end else begin
               want = next_gen_cells.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected %0d at %0d,%0d last=%0d, got %0d at %0d,%0d last=%0d",
                              $realtime, want.next_alive, want.row, want.col, want.last_cell,
                              got.next_alive, got.row, got.col, got.last_cell);
                  end
               end
            end
         end
      end
      pending_cells = next_gen_cells.size();
   end

endmodule

// ----- verif/life_next_generation_stream_test.sv -----
`timescale 1ns / 100ps
// life_next_generation_stream_test: drives frames of cells and flush items into the block
// under random sender gaps and receiver stalls and gives the verdict
// depends on lng_pkg, lng_req_if, lng_rsp_if, life_generation_checker, life_next_generation_stream

module life_next_generation_stream_test;
   import lng_pkg::*;

   localparam int   MAX_COLS      = 128;
   localparam int   MAX_ROWS      = 256;
   localparam int   RANDOM_ITEMS  = 1150;
   localparam int   SETTLE_CYCLES = 8;
   localparam int   CYCLE_LIMIT   = 300000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    send_gap_pct;
   int                    recv_stall_pct;
   int                    mismatches;
   int                    pending;
   int                    sent = 0;
   int                    cycles = 0;

   lng_req_if req_chan();
   lng_rsp_if rsp_chan();

   life_next_generation_stream #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan)
   );

   life_generation_checker #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) checker_i (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .mismatch_count(mismatches),
      .pending_cells (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int dim_of(input int value, input int hi);
      if (value < MIN_DIM) return MIN_DIM;
      if (value > hi) return hi;
      return value;
   endfunction

   task automatic send_item(input logic kind, input logic alive);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.cell_alive <= alive;
      do @(negedge clock); while (!req_chan.ready);
      @(posedge clock);
      sent++;
   endtask

   // wait until every expected cell is out and the pipeline is empty
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] rows_val,
                            input logic [CSR_DATA_W-1:0] cols_val);
      settle();
      write_reg(CSR_ROWS_IN_USE, rows_val);
      write_reg(CSR_COLS_IN_USE, cols_val);
   endtask

   task automatic run_frame(input int rows, input int cols, input int live_pct,
                            input int noise_pct, input int cut_at);
      int   total;
      int   n;
      logic kind;
      total = rows * cols + cols + 1;
      for (n = 0; n < total; n++) begin
         if (n == cut_at) break;
         kind = (n < rows * cols) ? ITEM_CELL : ITEM_FLUSH;
         if ($urandom_range(99) < noise_pct) kind = ~kind;
         send_item(kind, $urandom_range(99) < live_pct);
      end
   endtask

   initial begin
      int n;
      int frame_no;
      int rows_eff;
      int cols_eff;
      int rows_val;
      int cols_val;
      int pick;
      int live_pct;
      int noise_pct;
      int cut_at;
      bit restart;
      bit extreme;

      send_gap_pct = 24;
      recv_stall_pct = 65;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_ROWS_IN_USE;
      csr_wr_data <= '0;
      req_chan.valid <= 1'b0;
      req_chan.req_type <= ITEM_CELL;
      req_chan.cell_alive <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // the first 100 items of a frame at the reset sizes
      run_frame(45, 78, 35, 3, 100);

      // 3x3 grid from clamped values: vertical blinker, then a full grid with a
      // flush item in the middle and live cells below the grid
      configure(9'd0, 9'd2);
      for (n = 0; n < 9; n++) send_item(ITEM_CELL, n % 3 == 1);
      repeat (4) send_item(ITEM_FLUSH, 1'b0);
      for (n = 0; n < 9; n++) send_item(n == 4 ? ITEM_FLUSH : ITEM_CELL, 1'b1);
      repeat (4) send_item(ITEM_CELL, 1'b1);

      frame_no = 0;
      restart = 1;
      rows_eff = 3;
      cols_eff = 3;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            send_gap_pct = 24;
            recv_stall_pct = 65;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_gap_pct = 65;
            recv_stall_pct = 24;
         end else begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         live_pct = $urandom_range(70, 20);
         noise_pct = 3;
         cut_at = -1;
         extreme = (frame_no == 1 || frame_no == 4 || frame_no == 7);
         case (frame_no)
            1: begin
               // exact row maximum, column value with the unused top bit set
               configure(9'd256, 9'h103);
               rows_eff = 256;
               cols_eff = 3;
               cut_at = 150;
            end
            4: begin
               configure(9'd2, 9'd128);
               rows_eff = 3;
               cols_eff = 128;
               cut_at = 300;
            end
            7: begin
               configure(9'h1FF, 9'h0FF);
               rows_eff = 256;
               cols_eff = 128;
               cut_at = 150;
            end
            default: begin
               if (restart || $urandom_range(99) < 70) begin
                  rows_val = ($urandom_range(9) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
                  cols_val = ($urandom_range(9) == 0) ? $urandom_range(2, 0) : $urandom_range(12, 3);
                  rows_eff = dim_of(rows_val, MAX_ROWS);
                  cols_eff = dim_of(cols_val, MAX_COLS);
                  configure(9'(rows_val), {1'($urandom_range(1)), 8'(cols_val)});
               end
               pick = $urandom_range(99);
               if (pick < 12) cut_at = $urandom_range(rows_eff * cols_eff + cols_eff, 1);
               else if (pick < 18) noise_pct = 50;
            end
         endcase
         run_frame(rows_eff, cols_eff, live_pct, noise_pct, cut_at);
         restart = (cut_at >= 0) || extreme;
         frame_no++;
      end

      settle();
      @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
